@@ rtl/bcme_pkg.sv @@
// shared types and constants of the 4-d box centre morton encoder
// no dependencies
package bcme_pkg;

  localparam int COORD_BITS = 32;
  localparam int SLOT_BITS  = 16;
  localparam int NUM_AXES   = 4;
  localparam int FIELD_W    = 32;
  localparam int CODE_W     = 64;
  localparam int REG_IDX_W  = 3;

  // odd register indexes hold an axis upper bound
  localparam logic REG_IS_MAX = 1'b1;

  typedef struct packed {
    logic signed [FIELD_W-1:0] box_x_low;
    logic signed [FIELD_W-1:0] box_y_low;
    logic signed [FIELD_W-1:0] box_z_low;
    logic signed [FIELD_W-1:0] box_rad_low;
    logic signed [FIELD_W-1:0] box_x_high;
    logic signed [FIELD_W-1:0] box_y_high;
    logic signed [FIELD_W-1:0] box_z_high;
    logic signed [FIELD_W-1:0] box_rad_high;
  } box_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] morton_code;
    logic              bounds_error;
  } code_out_t;

endpackage

@@ rtl/box_centre_morton_encoder_4d_top.sv @@
// start to result strobe: centre register, prep stage, divider stages, output register
// throughput: one box per cycle; one divider stage per quotient bit sets depth
// busy is never high; results leave on a one-cycle strobe, no back-pressure
// reset: async active low, clears valid bits; bounds go to full signed range
// depends on bcme_pkg and bcme_quant
module box_centre_morton_encoder_4d_top
  import bcme_pkg::*;
#(
  parameter int CoordBits = COORD_BITS,
  parameter int SlotBits  = SLOT_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  box_in_t              box_i,
  output logic                 valid_o,
  output code_out_t            result_o,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [FIELD_W-1:0]   cfg_wdata_i
);

  localparam logic [CoordBits-1:0] MinRst = {1'b1, {(CoordBits-1){1'b0}}};
  localparam logic [CoordBits-1:0] MaxRst = {1'b0, {(CoordBits-1){1'b1}}};

  logic [CoordBits-1:0] min_q [NUM_AXES];
  logic [CoordBits-1:0] max_q [NUM_AXES];
  logic [CoordBits-1:0] lo    [NUM_AXES];
  logic [CoordBits-1:0] hi    [NUM_AXES];
  logic [CoordBits-1:0] cen_q [NUM_AXES];
  logic                 cen_vld_q;
  logic                 q_vld [NUM_AXES];
  logic [SlotBits-1:0]  slot  [NUM_AXES];
  logic [NUM_AXES-1:0]  q_err;
  logic [CODE_W-1:0]    code_d;
  logic                 out_vld_q;
  code_out_t            out_q;

  assign busy = 1'b0;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        min_q[a] <= MinRst;
        max_q[a] <= MaxRst;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i[0] == REG_IS_MAX) begin
        max_q[cfg_idx_i[REG_IDX_W-1:1]] <= CoordBits'($unsigned(cfg_wdata_i));
      end else begin
        min_q[cfg_idx_i[REG_IDX_W-1:1]] <= CoordBits'($unsigned(cfg_wdata_i));
      end
    end
  end

  // coordinates at internal width
  always_comb begin
    lo[0] = CoordBits'($unsigned(box_i.box_x_low));
    lo[1] = CoordBits'($unsigned(box_i.box_y_low));
    lo[2] = CoordBits'($unsigned(box_i.box_z_low));
    lo[3] = CoordBits'($unsigned(box_i.box_rad_low));
    hi[0] = CoordBits'($unsigned(box_i.box_x_high));
    hi[1] = CoordBits'($unsigned(box_i.box_y_high));
    hi[2] = CoordBits'($unsigned(box_i.box_z_high));
    hi[3] = CoordBits'($unsigned(box_i.box_rad_high));
  end

  // centre stage: floor of the half sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_vld_q <= 1'b0;
    end else begin
      cen_vld_q <= start;
    end
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    logic [CoordBits:0] sum;
    assign sum = {lo[a][CoordBits-1], lo[a]} + {hi[a][CoordBits-1], hi[a]};

    always_ff @(posedge clk_i) begin
      cen_q[a] <= sum[CoordBits:1];
    end

    bcme_quant #(
      .CoordBits(CoordBits),
      .SlotBits (SlotBits)
    ) u_quant (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .vld_i   (cen_vld_q),
      .centre_i(cen_q[a]),
      .min_i   (min_q[a]),
      .max_i   (max_q[a]),
      .vld_o   (q_vld[a]),
      .slot_o  (slot[a]),
      .err_o   (q_err[a])
    );
  end

  // bit interleave
  always_comb begin
    code_d = '0;
    for (int b = 0; b < SlotBits; b++) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        code_d[NUM_AXES*b + a] = slot[a][b];
      end
    end
  end

  // output beat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= q_vld[0];
    end
  end

  always_ff @(posedge clk_i) begin
    out_q.bounds_error <= |q_err;
    out_q.morton_code  <= (|q_err) ? '0 : code_d;
  end

  assign valid_o  = out_vld_q;
  assign result_o = out_q;

  // lanes move in lock step
  a_lanes_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_vld[0] == q_vld[1] && q_vld[0] == q_vld[2] && q_vld[0] == q_vld[3])
    else $error("axis lanes out of step");

  // error beats carry a zero code
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && result_o.bounds_error |-> result_o.morton_code == '0)
    else $error("error beat with nonzero code");

  // a lane result is always followed by a beat
  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_vld[0] |=> valid_o)
    else $error("lane result dropped");

endmodule

@@ rtl/bcme_quant.sv @@
// per-axis quantiser: bound check, range compare and a restoring divider
// with one quotient bit per pipeline stage; depends on bcme_pkg
module bcme_quant
  import bcme_pkg::*;
#(
  parameter int CoordBits = COORD_BITS,
  parameter int SlotBits  = SLOT_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 vld_i,
  input  logic [CoordBits-1:0] centre_i,
  input  logic [CoordBits-1:0] min_i,
  input  logic [CoordBits-1:0] max_i,
  output logic                 vld_o,
  output logic [SlotBits-1:0]  slot_o,
  output logic                 err_o
);

  localparam logic [SlotBits-1:0] SlotTop = '1;

  // stage arrays, entry 0 is the prep stage
  logic                 vld_q  [SlotBits+1];
  logic                 zero_q [SlotBits+1];
  logic                 sat_q  [SlotBits+1];
  logic                 err_q  [SlotBits+1];
  logic [CoordBits-1:0] rem_q  [SlotBits+1];
  logic [CoordBits-1:0] den_q  [SlotBits+1];
  logic [SlotBits-1:0]  quo_q  [SlotBits+1];

  logic [CoordBits:0]   num_d;
  logic [CoordBits-1:0] den_d;
  logic                 err_d;
  logic                 neg_d;

  // offset from the lower bound and bound span
  always_comb begin
    num_d = {centre_i[CoordBits-1], centre_i} - {min_i[CoordBits-1], min_i};
    den_d = max_i - min_i;
    err_d = $signed(max_i) <= $signed(min_i);
    neg_d = num_d[CoordBits];
  end

  // prep stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q[0] <= err_d | neg_d;
    sat_q[0]  <= !neg_d && (num_d[CoordBits-1:0] >= den_d);
    err_q[0]  <= err_d;
    rem_q[0]  <= num_d[CoordBits-1:0];
    den_q[0]  <= den_d;
    quo_q[0]  <= '0;
  end

  // one restoring divide step per stage
  for (genvar s = 0; s < SlotBits; s++) begin : g_step
    logic [CoordBits:0] shl;
    logic               ge;

    always_comb begin
      shl = {rem_q[s], 1'b0};
      ge  = shl >= {1'b0, den_q[s]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      zero_q[s+1] <= zero_q[s];
      sat_q[s+1]  <= sat_q[s];
      err_q[s+1]  <= err_q[s];
      den_q[s+1]  <= den_q[s];
      rem_q[s+1]  <= ge ? CoordBits'(shl - {1'b0, den_q[s]}) : shl[CoordBits-1:0];
      quo_q[s+1]  <= {quo_q[s][SlotBits-2:0], ge};
    end
  end

  // clamp to the slot range
  always_comb begin
    vld_o = vld_q[SlotBits];
    err_o = err_q[SlotBits];
    if (zero_q[SlotBits]) begin
      slot_o = '0;
    end else if (sat_q[SlotBits]) begin
      slot_o = SlotTop;
    end else begin
      slot_o = quo_q[SlotBits];
    end
  end

  // remainder stays below the divisor on the in-range path
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && !zero_q[0] && !sat_q[0] |=> rem_q[1] < den_q[1])
    else $error("divider remainder reached divisor");

  // degenerate bounds always take the zero path
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_o && err_o |-> slot_o == '0)
    else $error("degenerate axis gave nonzero slot");

  // prep flags are exclusive unless the bounds are degenerate
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> !(zero_q[0] && sat_q[0]) || err_q[0])
    else $error("zero and saturate both set");

endmodule
